### design/nf3_pkg.sv
// shared constants, types and register map of the 3x3 neighbourhood filter
package nf3_pkg;

  localparam int FRAC_BITS_DEF = 15;
  localparam int SAMPLE_W      = 16;
  localparam int NEIGH_N       = 8;
  localparam int SUM8_W        = 19;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_MODE     = 1'b0;
  localparam logic REG_STRENGTH = 1'b1;
  localparam logic [SAMPLE_W-1:0] STRENGTH_RESET = 16'd32768;

  typedef enum logic [2:0] {
    MODE_INVERT   = 3'd0,
    MODE_SOFTEN   = 3'd1,
    MODE_EXPAND   = 3'd2,
    MODE_CONTRACT = 3'd3,
    MODE_EDGE     = 3'd4,
    MODE_SLOPE    = 3'd5,
    MODE_CAVITY   = 3'd6,
    MODE_PEAKS    = 3'd7
  } nf3_mode_t;

  // sum of nine samples plus rounding, divided by nine via reciprocal
  localparam int SOFTEN_IN_W  = 20;
  localparam int SOFTEN_SHIFT = 23;
  localparam logic [SOFTEN_IN_W-1:0] SOFTEN_RECIP = 20'd932068;

  localparam int SQRT_RAD_W  = 32;
  localparam int SQRT_ROOT_W = 16;
  localparam int SQRT_STAGES = 4;
  localparam int SQRT_DIGITS = SQRT_ROOT_W / SQRT_STAGES;

endpackage

### design/nf3_if.sv
// valid/ready stream interfaces for neighbourhood windows and filtered samples
interface nf3_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] centre_sample;
  logic [15:0] left_sample;
  logic [15:0] right_sample;
  logic [15:0] up_sample;
  logic [15:0] down_sample;
  logic [15:0] upper_left_sample;
  logic [15:0] upper_right_sample;
  logic [15:0] lower_left_sample;
  logic [15:0] lower_right_sample;

  modport source (
    output valid, centre_sample, left_sample, right_sample, up_sample, down_sample,
           upper_left_sample, upper_right_sample, lower_left_sample, lower_right_sample,
    input  ready
  );
  modport sink (
    input  valid, centre_sample, left_sample, right_sample, up_sample, down_sample,
           upper_left_sample, upper_right_sample, lower_left_sample, lower_right_sample,
    output ready
  );
endinterface

interface nf3_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] filtered_sample;

  modport source (output valid, filtered_sample, input ready);
  modport sink (input valid, filtered_sample, output ready);
endinterface

### design/nf3_sqrt_pipe.sv
// pipelined restoring integer square root with remainder and side tag
module nf3_sqrt_pipe #(
  parameter int TAG_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [nf3_pkg::SQRT_RAD_W-1:0]    in_rad,
  input  logic [TAG_W-1:0]                  in_tag,
  output logic                              out_valid,
  output logic [nf3_pkg::SQRT_ROOT_W-1:0]   out_root,
  output logic [nf3_pkg::SQRT_ROOT_W:0]     out_rem,
  output logic [TAG_W-1:0]                  out_tag
);
  import nf3_pkg::*;

  localparam int REM_W = SQRT_ROOT_W + 2;

  logic [REM_W-1:0]       rem_r  [SQRT_STAGES];
  logic [SQRT_ROOT_W-1:0] root_r [SQRT_STAGES];
  logic [SQRT_RAD_W-1:0]  rad_r  [SQRT_STAGES];
  logic [TAG_W-1:0]       tag_r  [SQRT_STAGES];
  logic                   vld_r  [SQRT_STAGES];

  genvar g;
  for (g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic [REM_W-1:0]       rem_i;
    logic [SQRT_ROOT_W-1:0] root_i;
    logic [SQRT_RAD_W-1:0]  rad_i;
    logic [TAG_W-1:0]       tag_i;
    logic                   vld_i;
    logic [REM_W-1:0]       rem_nxt;
    logic [SQRT_ROOT_W-1:0] root_nxt;
    logic [SQRT_RAD_W-1:0]  rad_nxt;
    logic [REM_W-1:0]       trial;

    if (g == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign tag_i  = in_tag;
      assign vld_i  = in_valid;
    end else begin : g_next
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign rad_i  = rad_r[g-1];
      assign tag_i  = tag_r[g-1];
      assign vld_i  = vld_r[g-1];
    end

    // one result bit per step
    always_comb begin
      rem_nxt  = rem_i;
      root_nxt = root_i;
      rad_nxt  = rad_i;
      trial    = '0;
      for (int i = 0; i < SQRT_DIGITS; i++) begin
        rem_nxt = {rem_nxt[REM_W-3:0], rad_nxt[SQRT_RAD_W-1 -: 2]};
        rad_nxt = {rad_nxt[SQRT_RAD_W-3:0], 2'b00};
        trial   = {root_nxt, 2'b01};
        if (rem_nxt >= trial) begin
          rem_nxt  = rem_nxt - trial;
          root_nxt = {root_nxt[SQRT_ROOT_W-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[SQRT_ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        rad_r[g]  <= rad_nxt;
        tag_r[g]  <= tag_i;
      end
    end
  end

  assign out_valid = vld_r[SQRT_STAGES-1];
  assign out_root  = root_r[SQRT_STAGES-1];
  assign out_rem   = rem_r[SQRT_STAGES-1][SQRT_ROOT_W:0];
  assign out_tag   = tag_r[SQRT_STAGES-1];

  // remainder of a finished root never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, rem_r[SQRT_STAGES-1]} <= {2'b00, out_root, 1'b0}))
    else $error("sqrt remainder out of range");

endmodule

### design/neighbourhood_filter_3x3_blend_unit.sv
// top level of the 3x3 neighbourhood filter with centre blend
// Each 3x3 window of unsigned fixed-point samples yields one filtered sample, which
// leaves once the window has passed every pipeline stage; with the output taken every
// cycle the unit sustains one window per clock. The stages follow the slope path:
// squares, their sum, a four-stage square root of four result bits per stage, rounding
// and selection, the blend multiply and the final shift and clamp. A stalled output
// holds the whole pipeline. filter_mode and blend_strength sit on the APB port at
// byte addresses 0 and 4 and are to be written only while no window is in flight.
module neighbourhood_filter_3x3_blend_unit #(
  parameter int FRAC_BITS = nf3_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  nf3_in_if.sink                          in_bus,
  nf3_out_if.source                       out_bus,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nf3_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [nf3_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [nf3_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import nf3_pkg::*;

  localparam int ONE_W = FRAC_BITS + 1;
  localparam int MAG_W = (ONE_W > 18) ? ONE_W : 18;
  localparam int FW    = MAG_W + 1;
  localparam int DW    = FW + 1;
  localparam int PW    = DW + SAMPLE_W + 1;
  localparam int TAG_W = SAMPLE_W + FW + 1;
  localparam logic [MAG_W-1:0]     ONE_M  = MAG_W'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] ONE_P  = PW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);

  // configuration registers
  nf3_mode_t             mode_r;
  logic [SAMPLE_W-1:0]   strength_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_INVERT;
      strength_r <= STRENGTH_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_MODE:     mode_r     <= nf3_mode_t'(pwdata[2:0]);
        REG_STRENGTH: strength_r <= pwdata[SAMPLE_W-1:0];
        default:      mode_r     <= mode_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODE:     prdata = {29'd0, mode_r};
      REG_STRENGTH: prdata = {16'd0, strength_r};
      default:      prdata = '0;
    endcase
  end

  // pipeline advance
  logic en;
  logic v1_r, v2_r, v3_r, v8_r, v9_r, v10_r;
  logic sq_valid;

  assign en           = !v10_r || out_bus.ready;
  assign in_bus.ready = en;

  // stage 1: sum, extremes and differences
  logic [SAMPLE_W-1:0] nb [NEIGH_N];
  logic [SUM8_W-1:0]   s8_nxt;
  logic [SAMPLE_W-1:0] mx_nxt, mn_nxt;

  assign nb[0] = in_bus.left_sample;
  assign nb[1] = in_bus.right_sample;
  assign nb[2] = in_bus.up_sample;
  assign nb[3] = in_bus.down_sample;
  assign nb[4] = in_bus.upper_left_sample;
  assign nb[5] = in_bus.upper_right_sample;
  assign nb[6] = in_bus.lower_left_sample;
  assign nb[7] = in_bus.lower_right_sample;

  always_comb begin
    s8_nxt = '0;
    mx_nxt = in_bus.centre_sample;
    mn_nxt = in_bus.centre_sample;
    for (int i = 0; i < NEIGH_N; i++) begin
      s8_nxt = s8_nxt + SUM8_W'(nb[i]);
      if (nb[i] > mx_nxt) mx_nxt = nb[i];
      if (nb[i] < mn_nxt) mn_nxt = nb[i];
    end
  end

  logic [SAMPLE_W-1:0]        c1_r, mx1_r, mn1_r;
  logic [SUM8_W-1:0]          s81_r;
  logic signed [SAMPLE_W:0]   dx1_r, dy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= in_bus.centre_sample;
      mx1_r <= mx_nxt;
      mn1_r <= mn_nxt;
      s81_r <= s8_nxt;
      dx1_r <= $signed({1'b0, in_bus.right_sample}) - $signed({1'b0, in_bus.left_sample});
      dy1_r <= $signed({1'b0, in_bus.down_sample}) - $signed({1'b0, in_bus.up_sample});
    end
  end

  // stage 2: squares and soften product
  logic [SOFTEN_IN_W-1:0]     soft_in;
  logic [SAMPLE_W-1:0]        c2_r, mx2_r, mn2_r;
  logic [SUM8_W-1:0]          s82_r;
  logic [2*SAMPLE_W-1:0]      dx2_r, dy2_r;
  logic [2*SOFTEN_IN_W-1:0]   soft2_r;

  assign soft_in = SOFTEN_IN_W'(s81_r) + SOFTEN_IN_W'(c1_r) + SOFTEN_IN_W'(4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r    <= c1_r;
      mx2_r   <= mx1_r;
      mn2_r   <= mn1_r;
      s82_r   <= s81_r;
      dx2_r   <= (2*SAMPLE_W)'(dx1_r * dx1_r);
      dy2_r   <= (2*SAMPLE_W)'(dy1_r * dy1_r);
      soft2_r <= soft_in * SOFTEN_RECIP;
    end
  end

  // stage 3: slope radicand and every non-slope filter
  logic signed [SUM8_W+1:0]  cav_d;
  logic signed [SUM8_W+1:0]  cav_q;
  logic [MAG_W-1:0]          cav_f;
  logic signed [FW-1:0]      f_oth;
  logic [SAMPLE_W-1:0]       soft_f;

  assign soft_f = soft2_r[SOFTEN_SHIFT +: SAMPLE_W];

  always_comb begin
    cav_d = $signed({2'b00, s82_r}) - $signed({2'b00, c2_r, 3'b000});
    if (mode_r == MODE_PEAKS) begin
      cav_d = -cav_d;
    end
    cav_q = (cav_d + (SUM8_W+2)'(2)) >>> 2;
    if (cav_d <= 0) begin
      cav_f = '0;
    end else if (MAG_W'(cav_q[SUM8_W-1:0]) > ONE_M) begin
      cav_f = ONE_M;
    end else begin
      cav_f = MAG_W'(cav_q[SUM8_W-1:0]);
    end
  end

  always_comb begin
    unique case (mode_r) inside
      MODE_INVERT:   f_oth = $signed({1'b0, ONE_M}) - $signed(FW'(c2_r));
      MODE_SOFTEN:   f_oth = $signed(FW'(soft_f));
      MODE_EXPAND:   f_oth = $signed(FW'(mx2_r));
      MODE_CONTRACT: f_oth = $signed(FW'(mn2_r));
      MODE_EDGE:     f_oth = $signed(FW'(mx2_r - mn2_r));
      MODE_CAVITY, MODE_PEAKS: f_oth = $signed({1'b0, cav_f});
      default:       f_oth = '0;
    endcase
  end

  logic [2*SAMPLE_W:0]   n3_r;
  logic [TAG_W-1:0]      tag3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3_r   <= {1'b0, dx2_r} + {1'b0, dy2_r};
      tag3_r <= {c2_r, f_oth, (dx2_r[0] ^ dy2_r[0])};
    end
  end

  // stages 4 to 7: square root of half the radicand
  logic [SQRT_ROOT_W-1:0] sq_root;
  logic [SQRT_ROOT_W:0]   sq_rem;
  logic [TAG_W-1:0]       sq_tag;

  nf3_sqrt_pipe #(
    .TAG_W (TAG_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_rad    (n3_r[2*SAMPLE_W:1]),
    .in_tag    (tag3_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_rem   (sq_rem),
    .out_tag   (sq_tag)
  );

  // stage 8: round slope, select filter, difference to centre
  logic [SAMPLE_W-1:0]   c7;
  logic signed [FW-1:0]  f7_oth;
  logic                  n_lsb;
  logic                  rnd_up;
  logic [MAG_W-1:0]      k_ext;
  logic [MAG_W-1:0]      slope_f;
  logic signed [FW-1:0]  f7;

  assign c7     = sq_tag[TAG_W-1 -: SAMPLE_W];
  assign f7_oth = $signed(sq_tag[FW:1]);
  assign n_lsb  = sq_tag[0];
  assign rnd_up = {sq_rem, n_lsb} > {1'b0, sq_root, 1'b0};
  assign k_ext  = MAG_W'(sq_root) + MAG_W'(rnd_up);
  assign slope_f = (k_ext > ONE_M) ? ONE_M : k_ext;
  assign f7     = (mode_r == MODE_SLOPE) ? $signed({1'b0, slope_f}) : f7_oth;

  logic [SAMPLE_W-1:0]   c8_r;
  logic signed [DW-1:0]  d8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c8_r <= c7;
      d8_r <= DW'(f7) - $signed(DW'(c7));
    end
  end

  // stage 9: blend product
  logic [SAMPLE_W-1:0]   c9_r;
  logic signed [PW-1:0]  p9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c9_r <= c8_r;
      p9_r <= PW'(d8_r * $signed({1'b0, strength_r}));
    end
  end

  // stage 10: round, add centre, clamp
  logic signed [PW-1:0]  q10;
  logic signed [PW-1:0]  r10;
  logic [MAG_W-1:0]      clamp_nxt;
  logic [MAG_W-1:0]      clamp_r;

  assign q10 = (p9_r + HALF_P) >>> FRAC_BITS;
  assign r10 = q10 + $signed(PW'(c9_r));

  always_comb begin
    if (r10 < 0) begin
      clamp_nxt = '0;
    end else if (r10 > ONE_P) begin
      clamp_nxt = ONE_M;
    end else begin
      clamp_nxt = r10[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (en) begin
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clamp_r <= clamp_nxt;
    end
  end

  assign out_bus.valid           = v10_r;
  assign out_bus.filtered_sample = clamp_r[SAMPLE_W-1:0];

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.ready) |-> !in_bus.ready)
    else $error("input taken while output stalled");

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (clamp_r <= ONE_M))
    else $error("filtered sample above one");

  a_output_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> $past(v9_r))
    else $error("result without an item in flight");

endmodule

### test/testbench.sv
// self-checking testbench of the 3x3 neighbourhood filter with centre blend
`timescale 1ns / 100ps

typedef logic [15:0] window_t [9];

class sample_scoreboard;
  localparam int FRAC = nf3_pkg::FRAC_BITS_DEF;

  nf3_pkg::nf3_mode_t mode;
  logic [15:0]        strength;
  logic [15:0]        expected_samples[$];
  int                 errors;
  int                 windows_seen;
  int                 samples_checked;

  function new();
    mode            = nf3_pkg::MODE_INVERT;
    strength        = nf3_pkg::STRENGTH_RESET;
    errors          = 0;
    windows_seen    = 0;
    samples_checked = 0;
  endfunction

  static function longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  static function longint clamp_unit(longint v);
    longint one;
    one = longint'(1) << FRAC;
    if (v < 0) return 0;
    if (v > one) return one;
    return v;
  endfunction

  function logic [15:0] predict_sample(window_t w);
    longint          c, s8, mx, mn, f, p, r, d, dx, dy, one, sv;
    longint unsigned n, k, uone;
    one  = longint'(1) << FRAC;
    uone = longint'(1) << FRAC;
    c    = longint'(w[0]);
    s8   = 0;
    mx   = c;
    mn   = c;
    for (int i = 1; i < 9; i++) begin
      sv = longint'(w[i]);
      s8 += sv;
      if (sv > mx) mx = sv;
      if (sv < mn) mn = sv;
    end
    case (mode)
      nf3_pkg::MODE_INVERT:   f = one - c;
      nf3_pkg::MODE_SOFTEN:   f = (s8 + c + 4) / 9;
      nf3_pkg::MODE_EXPAND:   f = mx;
      nf3_pkg::MODE_CONTRACT: f = mn;
      nf3_pkg::MODE_EDGE:     f = mx - mn;
      nf3_pkg::MODE_SLOPE: begin
        dx = longint'(w[2]) - longint'(w[1]);
        dy = longint'(w[4]) - longint'(w[3]);
        n  = longint'(dx * dx + dy * dy);
        if (n >= 2 * uone * uone) begin
          f = one;
        end else begin
          k = int_sqrt(n >> 1);
          if (2 * n >= 4 * k * k + 4 * k + 1) k++;
          if (k > uone) k = uone;
          f = longint'(k);
        end
      end
      nf3_pkg::MODE_CAVITY: begin
        d = s8 - 8 * c;
        f = (d <= 0) ? 0 : clamp_unit((d + 2) / 4);
      end
      default: begin
        d = 8 * c - s8;
        f = (d <= 0) ? 0 : clamp_unit((d + 2) / 4);
      end
    endcase
    p = (f - c) * longint'(strength);
    r = c + ((p + one / 2) >>> FRAC);
    r = clamp_unit(r);
    return r[15:0];
  endfunction

  function void note_window(window_t w);
    expected_samples.push_back(predict_sample(w));
    windows_seen++;
  endfunction

  function void check_sample(logic [15:0] got);
    logic [15:0] want;
    if (expected_samples.size() == 0) begin
      $error("filtered_sample: expected none, actual %0d", got);
      errors++;
      return;
    end
    want = expected_samples.pop_front();
    samples_checked++;
    if (got !== want) begin
      $error("filtered_sample: expected %0d, actual %0d", want, got);
      errors++;
    end
  endfunction

  function int pending();
    return expected_samples.size();
  endfunction
endclass

module testbench;
  import nf3_pkg::*;

  localparam int          SETTLE_CYCLES = 14;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          CYCLE_LIMIT   = 300000;
  localparam int          PHASES        = 24;
  localparam int          PHASE_ITEMS   = 48;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MODE     = {REG_MODE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_STRENGTH = {REG_STRENGTH, 2'b00};

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int send_idle_pct;
  int recv_stall_pct;
  bit pressure_on;
  int settings_used;

  sample_scoreboard sb = new();

  nf3_in_if  in_if ();
  nf3_out_if out_if ();

  neighbourhood_filter_3x3_blend_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_sample(out_if.filtered_sample);
      if (pressure_on && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_and_configure(nf3_mode_t m, logic [15:0] s);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(ADDR_MODE, CFG_DATA_W'(m));
    sb.mode = m;
    cfg_write(ADDR_STRENGTH, CFG_DATA_W'(s));
    sb.strength = s;
    settings_used++;
  endtask

  task automatic send_window(window_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid              <= 1'b1;
    in_if.centre_sample      <= w[0];
    in_if.left_sample        <= w[1];
    in_if.right_sample       <= w[2];
    in_if.up_sample          <= w[3];
    in_if.down_sample        <= w[4];
    in_if.upper_left_sample  <= w[5];
    in_if.upper_right_sample <= w[6];
    in_if.lower_left_sample  <= w[7];
    in_if.lower_right_sample <= w[8];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_window(w);
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(65535));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic window_t random_window();
    window_t w;
    int      base;
    int      v;
    if ($urandom_range(2) == 0) begin
      // smooth neighbourhood around one level
      base = $urandom_range(32768);
      for (int i = 0; i < 9; i++) begin
        v = base + $urandom_range(128) - 64;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        w[i] = 16'(v);
      end
    end else begin
      for (int i = 0; i < 9; i++) w[i] = random_sample();
    end
    return w;
  endfunction

  initial begin : stimulus
    window_t     w;
    window_t     directed [3];
    logic [15:0] s;
    int          idle_kind;

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_on    = 1'b0;
    settings_used  = 0;

    rst_n                    <= 1'b0;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    in_if.valid              <= 1'b0;
    in_if.centre_sample      <= '0;
    in_if.left_sample        <= '0;
    in_if.right_sample       <= '0;
    in_if.up_sample          <= '0;
    in_if.down_sample        <= '0;
    in_if.upper_left_sample  <= '0;
    in_if.upper_right_sample <= '0;
    in_if.lower_left_sample  <= '0;
    in_if.lower_right_sample <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values first: invert at full strength
    directed[0] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    directed[1] = '{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    directed[2] = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0,
                    16'd32768, 16'd32767, 16'd1, 16'hFFFF};
    for (int m = 0; m < 8; m++) begin
      if (m != 0)
        drain_and_configure(nf3_mode_t'(m), (m % 2 == 0) ? 16'd32768 : 16'hFFFF);
      for (int i = 0; i < 3; i++) send_window(directed[i]);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 5)
        0:       s = 16'd32768;
        1:       s = 16'd0;
        2:       s = 16'hFFFF;
        3:       s = 16'($urandom_range(32768));
        default: s = 16'($urandom_range(65535));
      endcase
      drain_and_configure(nf3_mode_t'(phase % 8), s);
      idle_kind = (phase + phase / 8) % 4;
      case (idle_kind)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (phase == 0) pressure_on = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        w = random_window();
        send_window(w);
      end
    end

    in_if.valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d windows and %0d checked samples", sb.windows_seen,
             sb.samples_checked);
    $display("over %0d register settings, all eight filter modes and four idle mixes",
             settings_used + 1);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

### sim.f
design/nf3_pkg.sv
design/nf3_if.sv
design/nf3_sqrt_pipe.sv
design/neighbourhood_filter_3x3_blend_unit.sv
test/testbench.sv
